// ----- rtl/sss_pkg.sv -----
package sss_pkg;

   localparam int REQ_DATA_BITS = 104;
   localparam int REQ_USER_BITS = 3;
   localparam int RSP_DATA_BITS = 176;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [2:0] KIND_CONFIGURED = 3'd0;
   localparam logic [2:0] KIND_START      = 3'd1;
   localparam logic [2:0] KIND_STOP       = 3'd2;
   localparam logic [2:0] KIND_RESET      = 3'd3;
   localparam logic [2:0] KIND_CONTINUE   = 3'd4;
   localparam logic [2:0] KIND_CHECK      = 3'd5;
   localparam logic [2:0] KIND_DWELL_DONE = 3'd6;

   localparam logic [2:0] STATUS_UNINIT   = 3'd0;
   localparam logic [2:0] STATUS_READY    = 3'd1;
   localparam logic [2:0] STATUS_SCANNING = 3'd2;
   localparam logic [2:0] STATUS_STOPPING = 3'd3;
   localparam logic [2:0] STATUS_WAITING  = 3'd4;
   localparam logic [2:0] STATUS_FINISHED = 3'd5;
   localparam logic [2:0] STATUS_ERROR    = 3'd6;

   localparam logic [1:0] REPLY_OK     = 2'd0;
   localparam logic [1:0] REPLY_WRONG  = 2'd1;
   localparam logic [1:0] REPLY_DRIVER = 2'd2;

   localparam logic [2:0] REG_YAW_START   = 3'd0;
   localparam logic [2:0] REG_YAW_END     = 3'd1;
   localparam logic [2:0] REG_YAW_STEP    = 3'd2;
   localparam logic [2:0] REG_PITCH_START = 3'd3;
   localparam logic [2:0] REG_PITCH_END   = 3'd4;
   localparam logic [2:0] REG_PITCH_STEP  = 3'd5;
   localparam logic [2:0] REG_AUTO_MODE   = 3'd6;

   typedef enum logic [6:0] {
      ST_UNINIT   = 7'b0000001,
      ST_READY    = 7'b0000010,
      ST_SCANNING = 7'b0000100,
      ST_STOPPING = 7'b0001000,
      ST_WAITING  = 7'b0010000,
      ST_FINISHED = 7'b0100000,
      ST_ERROR    = 7'b1000000
   } st_type;

   typedef struct packed {
      logic signed [31:0] yaw_start;
      logic signed [31:0] yaw_end;
      logic [30:0]        yaw_step;
      logic signed [31:0] pitch_start;
      logic signed [31:0] pitch_end;
      logic [30:0]        pitch_step;
      logic               auto_mode;
   } cfg_type;

   typedef struct packed {
      st_type st;
      logic   row_backward;
      logic   yaw_motor_on;
      logic   pitch_motor_on;
   } ctl_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic               yaw_at_target;
      logic               pitch_at_target;
      logic [31:0]        yaw_position;
      logic [31:0]        pitch_position;
      logic signed [31:0] sample_value;
      logic               driver_fault;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [1:0]         reply;
      logic signed [31:0] target_yaw_out;
      logic signed [31:0] target_pitch_out;
      logic               load_target;
      logic               yaw_drive;
      logic               pitch_drive;
      logic               point_valid;
      logic [31:0]        point_yaw;
      logic [31:0]        point_pitch;
      logic signed [31:0] point_value;
      logic               start_dwell;
   } rsp_type;

   function automatic logic [2:0] status_code(input st_type st);
      logic [2:0] code;
      case (st)
         ST_UNINIT:   code = STATUS_UNINIT;
         ST_READY:    code = STATUS_READY;
         ST_SCANNING: code = STATUS_SCANNING;
         ST_STOPPING: code = STATUS_STOPPING;
         ST_WAITING:  code = STATUS_WAITING;
         ST_FINISHED: code = STATUS_FINISHED;
         ST_ERROR:    code = STATUS_ERROR;
         default:     code = STATUS_UNINIT;
      endcase
      return code;
   endfunction

endpackage

// ----- rtl/serpentine_scan_sequencer.sv -----
// Serpentine raster scan sequencer. Each request on req_ is one event (command, position
// check or dwell done, selected by req_tuser) and yields exactly one response on rsp_ with
// the scan status, the reply code, the current targets, the motor drive flags and, where a
// point was reached, the point record. A request is registered on entry, decoded against the
// scan state in a single combinational step, and the response is registered on exit; one
// request is taken in every cycle while the response side keeps up. The scan state updates
// as a request passes into the response register, so back-to-back events see each other's
// effect. Targets are POSITION_BITS wide and wrap at that width; the response shows them
// sign-extended or truncated to 32 bits. Registers on the csr_ port are to be written by the
// user only while no request is in flight; the block itself does not enforce this.
module serpentine_scan_sequencer #(
   parameter int POSITION_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // kind
   input  logic [sss_pkg::REQ_USER_BITS-1:0]    req_tuser,
   // yaw_at_target, pitch_at_target, yaw_position, pitch_position, sample_value, driver_fault
   input  logic [sss_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // status, reply, target_yaw_out, target_pitch_out, load_target, yaw_drive, pitch_drive,
   // point_valid, point_yaw, point_pitch, point_value, start_dwell
   output logic [sss_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [sss_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sss_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import sss_pkg::*;

   cfg_type                     cfg;
   req_type                     req_in;
   req_type                     req_ff;
   logic                        req_valid_ff;
   rsp_type                     rsp_in;
   rsp_type                     rsp_ff;
   logic                        rsp_valid_ff;
   ctl_type                     ctl_ff;
   ctl_type                     ctl_in;
   logic signed [POSITION_BITS-1:0] yaw_target_ff;
   logic signed [POSITION_BITS-1:0] yaw_target_in;
   logic signed [POSITION_BITS-1:0] pitch_target_ff;
   logic signed [POSITION_BITS-1:0] pitch_target_in;
   logic                        rsp_free;
   logic                        advance;

   sss_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_in.kind            = req_tuser;
   assign req_in.yaw_at_target   = req_tdata[0];
   assign req_in.pitch_at_target = req_tdata[1];
   assign req_in.yaw_position    = req_tdata[33:2];
   assign req_in.pitch_position  = req_tdata[65:34];
   assign req_in.sample_value    = req_tdata[97:66];
   assign req_in.driver_fault    = req_tdata[98];

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = req_valid_ff && rsp_free;
   assign req_tready = !req_valid_ff || rsp_free;

   sss_step #(
      .POSITION_BITS (POSITION_BITS)
   ) u_step (
      .cfg       (cfg),
      .req       (req_ff),
      .ctl_cur   (ctl_ff),
      .yaw_cur   (yaw_target_ff),
      .pitch_cur (pitch_target_ff),
      .ctl_nxt   (ctl_in),
      .yaw_nxt   (yaw_target_in),
      .pitch_nxt (pitch_target_in),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         ctl_ff          <= '{st: ST_UNINIT, row_backward: 1'b0,
                              yaw_motor_on: 1'b0, pitch_motor_on: 1'b0};
         yaw_target_ff   <= '0;
         pitch_target_ff <= '0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (advance) begin
            ctl_ff          <= ctl_in;
            yaw_target_ff   <= yaw_target_in;
            pitch_target_ff <= pitch_target_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0,
                        rsp_ff.start_dwell,
                        rsp_ff.point_value,
                        rsp_ff.point_pitch,
                        rsp_ff.point_yaw,
                        rsp_ff.point_valid,
                        rsp_ff.pitch_drive,
                        rsp_ff.yaw_drive,
                        rsp_ff.load_target,
                        rsp_ff.target_pitch_out,
                        rsp_ff.target_yaw_out,
                        rsp_ff.reply,
                        rsp_ff.status};

endmodule

// ----- rtl/sss_csr_regs.sv -----
module sss_csr_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [sss_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sss_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output sss_pkg::cfg_type                     cfg
);
   import sss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_YAW_START:   cfg_in.yaw_start   = csr_wdata;
            REG_YAW_END:     cfg_in.yaw_end     = csr_wdata;
            REG_YAW_STEP:    cfg_in.yaw_step    = csr_wdata[30:0];
            REG_PITCH_START: cfg_in.pitch_start = csr_wdata;
            REG_PITCH_END:   cfg_in.pitch_end   = csr_wdata;
            REG_PITCH_STEP:  cfg_in.pitch_step  = csr_wdata[30:0];
            REG_AUTO_MODE:   cfg_in.auto_mode   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/sss_step.sv -----
module sss_step #(
   parameter int POSITION_BITS = 32
) (
   input  sss_pkg::cfg_type                  cfg,
   input  sss_pkg::req_type                  req,
   input  sss_pkg::ctl_type                  ctl_cur,
   input  logic signed [POSITION_BITS-1:0]   yaw_cur,
   input  logic signed [POSITION_BITS-1:0]   pitch_cur,
   output sss_pkg::ctl_type                  ctl_nxt,
   output logic signed [POSITION_BITS-1:0]   yaw_nxt,
   output logic signed [POSITION_BITS-1:0]   pitch_nxt,
   output sss_pkg::rsp_type                  rsp
);
   import sss_pkg::*;

   localparam int PB = POSITION_BITS;

   logic [63:0]              yaw_step64;
   logic [63:0]              pitch_step64;
   logic [63:0]              yaw_start64;
   logic [63:0]              pitch_start64;
   logic signed [PB-1:0]     yaw_step_p;
   logic signed [PB-1:0]     pitch_step_p;
   logic signed [PB-1:0]     yaw_cand;
   logic signed [PB-1:0]     pitch_adv;
   logic signed [PB-1:0]     pitch_sel;
   logic signed [63:0]       yaw_cand_ext;
   logic signed [63:0]       pitch_sel_ext;
   logic signed [63:0]       yaw_out_ext;
   logic signed [63:0]       pitch_out_ext;
   logic                     row_over;
   logic                     past_end;
   logic                     do_point;
   logic                     dwell;
   logic [1:0]               reply;
   logic                     load;

   assign yaw_step64    = {33'd0, cfg.yaw_step};
   assign pitch_step64  = {33'd0, cfg.pitch_step};
   assign yaw_start64   = 64'(cfg.yaw_start);
   assign pitch_start64 = 64'(cfg.pitch_start);
   assign yaw_step_p    = yaw_step64[PB-1:0];
   assign pitch_step_p  = pitch_step64[PB-1:0];

   // Next point of the row and the row change run in parallel with the control decode.
   assign yaw_cand      = ctl_cur.row_backward ? yaw_cur - yaw_step_p : yaw_cur + yaw_step_p;
   assign yaw_cand_ext  = 64'(yaw_cand);
   assign row_over      = ctl_cur.row_backward ? (yaw_cand_ext < 64'(cfg.yaw_start))
                                               : (yaw_cand_ext > 64'(cfg.yaw_end));
   assign pitch_adv     = pitch_cur + pitch_step_p;
   assign pitch_sel     = row_over ? pitch_adv : pitch_cur;
   assign pitch_sel_ext = 64'(pitch_sel);
   assign past_end      = pitch_sel_ext > 64'(cfg.pitch_end);

   always_comb begin
      ctl_nxt   = ctl_cur;
      yaw_nxt   = yaw_cur;
      pitch_nxt = pitch_cur;
      reply     = REPLY_OK;
      load      = 1'b0;
      dwell     = 1'b0;
      do_point  = 1'b0;

      case (req.kind)
         KIND_CONFIGURED: begin
            if (ctl_cur.st != ST_READY && ctl_cur.st != ST_UNINIT) begin
               reply = REPLY_WRONG;
            end else if (req.driver_fault) begin
               reply = REPLY_DRIVER;
            end else begin
               ctl_nxt.yaw_motor_on   = 1'b0;
               ctl_nxt.pitch_motor_on = 1'b0;
               ctl_nxt.st             = ST_READY;
            end
         end
         KIND_START: begin
            if (ctl_cur.st != ST_READY) begin
               reply = REPLY_WRONG;
            end else begin
               yaw_nxt              = yaw_start64[PB-1:0];
               pitch_nxt            = pitch_start64[PB-1:0];
               ctl_nxt.row_backward = 1'b0;
               load                 = 1'b1;
               if (req.driver_fault) begin
                  reply = REPLY_DRIVER;
               end else begin
                  ctl_nxt.st = ST_SCANNING;
               end
            end
         end
         KIND_STOP: begin
            if (ctl_cur.st == ST_WAITING) begin
               ctl_nxt.st = ST_FINISHED;
            end else if (ctl_cur.st == ST_SCANNING) begin
               ctl_nxt.st = ST_STOPPING;
            end else begin
               reply = REPLY_WRONG;
            end
         end
         KIND_RESET: begin
            if (ctl_cur.st == ST_FINISHED || ctl_cur.st == ST_ERROR) begin
               ctl_nxt.st = ST_READY;
            end else begin
               reply = REPLY_WRONG;
            end
         end
         KIND_CONTINUE: begin
            if (cfg.auto_mode || ctl_cur.st != ST_WAITING) begin
               reply = REPLY_WRONG;
            end else begin
               load = 1'b1;
               if (req.driver_fault) begin
                  ctl_nxt.st = ST_ERROR;
                  reply      = REPLY_DRIVER;
               end else begin
                  ctl_nxt.st = ST_SCANNING;
               end
            end
         end
         KIND_CHECK: begin
            if (ctl_cur.st == ST_STOPPING) begin
               ctl_nxt.st = ST_FINISHED;
            end else if (ctl_cur.st == ST_SCANNING) begin
               if (!req.yaw_at_target) begin
                  if (!ctl_cur.yaw_motor_on) begin
                     if (req.driver_fault) begin
                        ctl_nxt.st = ST_ERROR;
                        reply      = REPLY_DRIVER;
                     end else begin
                        ctl_nxt.yaw_motor_on = 1'b1;
                     end
                  end
               end else if (req.driver_fault) begin
                  ctl_nxt.st = ST_ERROR;
                  reply      = REPLY_DRIVER;
               end else begin
                  ctl_nxt.yaw_motor_on = 1'b0;
                  if (!req.pitch_at_target) begin
                     ctl_nxt.pitch_motor_on = 1'b1;
                  end else begin
                     ctl_nxt.pitch_motor_on = 1'b0;
                     if (cfg.auto_mode) begin
                        dwell = 1'b1;
                     end else begin
                        do_point = 1'b1;
                     end
                  end
               end
            end
         end
         KIND_DWELL_DONE: begin
            if (cfg.auto_mode) begin
               if (ctl_cur.st == ST_STOPPING) begin
                  ctl_nxt.st = ST_FINISHED;
               end else if (ctl_cur.st == ST_SCANNING) begin
                  if (req.driver_fault) begin
                     ctl_nxt.st = ST_ERROR;
                     reply      = REPLY_DRIVER;
                  end else begin
                     do_point = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // A recorded point moves along the row, or turns the row when yaw runs past its end.
      if (do_point) begin
         if (row_over) begin
            pitch_nxt            = pitch_adv;
            ctl_nxt.row_backward = !ctl_cur.row_backward;
         end else begin
            yaw_nxt = yaw_cand;
         end
         if (past_end) begin
            ctl_nxt.st = ST_FINISHED;
         end else if (cfg.auto_mode) begin
            load = 1'b1;
         end else begin
            ctl_nxt.st = ST_WAITING;
         end
      end
   end

   assign yaw_out_ext   = 64'(yaw_nxt);
   assign pitch_out_ext = 64'(pitch_nxt);

   always_comb begin
      rsp.status           = status_code(ctl_nxt.st);
      rsp.reply            = reply;
      rsp.target_yaw_out   = yaw_out_ext[31:0];
      rsp.target_pitch_out = pitch_out_ext[31:0];
      rsp.load_target      = load;
      rsp.yaw_drive        = ctl_nxt.yaw_motor_on;
      rsp.pitch_drive      = ctl_nxt.pitch_motor_on;
      rsp.point_valid      = do_point;
      rsp.point_yaw        = do_point ? req.yaw_position : 32'd0;
      rsp.point_pitch      = do_point ? req.pitch_position : 32'd0;
      rsp.point_value      = (do_point && cfg.auto_mode) ? req.sample_value : 32'sd0;
      rsp.start_dwell      = dwell;
   end

endmodule

// ----- rtl/sss_checker.sv -----
module sss_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic [sss_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready
);
   import sss_pkg::*;

   logic [2:0] status;
   logic [1:0] reply;
   logic       point_valid;
   logic       start_dwell;

   assign status      = rsp_tdata[2:0];
   assign reply       = rsp_tdata[4:3];
   assign point_valid = rsp_tdata[72];
   assign start_dwell = rsp_tdata[169];

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_point_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && point_valid |-> reply == REPLY_OK)
      else $error("point record with a failing reply");

   a_dwell_scanning: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && start_dwell |-> status == STATUS_SCANNING)
      else $error("dwell requested outside a scan");

   a_driver_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && reply == REPLY_DRIVER |->
         status == STATUS_ERROR || status == STATUS_READY || status == STATUS_UNINIT)
      else $error("driver error reply with an unexpected status");

endmodule

bind serpentine_scan_sequencer sss_checker u_sss_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ----- test/tb.sv -----
module tb;
   import sss_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   // kind
   logic [REQ_USER_BITS-1:0] req_tuser = '0;
   // yaw_at_target, pitch_at_target, yaw_position, pitch_position, sample_value, driver_fault
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // status, reply, target_yaw_out, target_pitch_out, load_target, yaw_drive, pitch_drive,
   // point_valid, point_yaw, point_pitch, point_value, start_dwell
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   serpentine_scan_sequencer u_dut (
      .clock(clock),
      .reset(reset),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scan predictor state and the register copy it works from.
   cfg_type grid_cfg = '0;
   logic [2:0] scan_state = STATUS_UNINIT;
   logic row_back = 1'b0;
   logic yaw_on = 1'b0;
   logic pitch_on = 1'b0;
   logic [31:0] yaw_tgt = '0;
   logic [31:0] pitch_tgt = '0;
   logic dwell_asked = 1'b0;

   rsp_type expected_rsp[$];
   int mismatches = 0;
   int responses_checked = 0;
   int items_sent = 0;
   int points_seen = 0;
   int scans_done = 0;
   int settings_used = 0;
   int burst_left = 0;
   int extremes_used = 0;
   int cycles = 0;
   int stall_mode = 0;
   int stall_left = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 20)
         $display("mismatch on response %0d: %s is %0h, expected %0h",
                  responses_checked, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   function automatic void record_point(input req_type r, inout rsp_type o);
      o.point_valid = 1'b1;
      o.point_yaw = r.yaw_position;
      o.point_pitch = r.pitch_position;
      o.point_value = grid_cfg.auto_mode ? r.sample_value : '0;
      points_seen++;
      yaw_tgt = row_back ? yaw_tgt - grid_cfg.yaw_step : yaw_tgt + grid_cfg.yaw_step;
      if (row_back ? $signed(yaw_tgt) < $signed(grid_cfg.yaw_start)
                   : $signed(yaw_tgt) > $signed(grid_cfg.yaw_end)) begin
         yaw_tgt = row_back ? yaw_tgt + grid_cfg.yaw_step : yaw_tgt - grid_cfg.yaw_step;
         pitch_tgt = pitch_tgt + grid_cfg.pitch_step;
         row_back = !row_back;
      end
      if ($signed(pitch_tgt) > $signed(grid_cfg.pitch_end)) scan_state = STATUS_FINISHED;
      else if (grid_cfg.auto_mode) o.load_target = 1'b1;
      else scan_state = STATUS_WAITING;
   endfunction

   function automatic rsp_type scan_step(input req_type r);
      rsp_type o;
      logic [2:0] prev;
      o = '0;
      o.reply = REPLY_OK;
      prev = scan_state;
      case (r.kind)
         KIND_CONFIGURED: begin
            if (scan_state != STATUS_READY && scan_state != STATUS_UNINIT) begin
               o.reply = REPLY_WRONG;
            end else if (r.driver_fault) begin
               o.reply = REPLY_DRIVER;
            end else begin
               yaw_on = 1'b0;
               pitch_on = 1'b0;
               scan_state = STATUS_READY;
            end
         end
         KIND_START: begin
            if (scan_state != STATUS_READY) begin
               o.reply = REPLY_WRONG;
            end else begin
               yaw_tgt = grid_cfg.yaw_start;
               pitch_tgt = grid_cfg.pitch_start;
               row_back = 1'b0;
               o.load_target = 1'b1;
               if (r.driver_fault) o.reply = REPLY_DRIVER;
               else scan_state = STATUS_SCANNING;
            end
         end
         KIND_STOP: begin
            if (scan_state == STATUS_WAITING) scan_state = STATUS_FINISHED;
            else if (scan_state == STATUS_SCANNING) scan_state = STATUS_STOPPING;
            else o.reply = REPLY_WRONG;
         end
         KIND_RESET: begin
            if (scan_state == STATUS_FINISHED || scan_state == STATUS_ERROR)
               scan_state = STATUS_READY;
            else
               o.reply = REPLY_WRONG;
         end
         KIND_CONTINUE: begin
            if (grid_cfg.auto_mode || scan_state != STATUS_WAITING) begin
               o.reply = REPLY_WRONG;
            end else begin
               o.load_target = 1'b1;
               if (r.driver_fault) begin
                  scan_state = STATUS_ERROR;
                  o.reply = REPLY_DRIVER;
               end else begin
                  scan_state = STATUS_SCANNING;
               end
            end
         end
         KIND_CHECK: begin
            if (scan_state == STATUS_STOPPING) begin
               scan_state = STATUS_FINISHED;
            end else if (scan_state == STATUS_SCANNING) begin
               // A fault is ignored only while yaw is off target and its motor already runs; else it is an error.
               if (!r.yaw_at_target) begin
                  if (!yaw_on) begin
                     if (r.driver_fault) begin
                        scan_state = STATUS_ERROR;
                        o.reply = REPLY_DRIVER;
                     end else begin
                        yaw_on = 1'b1;
                     end
                  end
               end else if (r.driver_fault) begin
                  scan_state = STATUS_ERROR;
                  o.reply = REPLY_DRIVER;
               end else begin
                  yaw_on = 1'b0;
                  if (!r.pitch_at_target) begin
                     pitch_on = 1'b1;
                  end else begin
                     pitch_on = 1'b0;
                     if (grid_cfg.auto_mode) o.start_dwell = 1'b1;
                     else record_point(r, o);
                  end
               end
            end
         end
         KIND_DWELL_DONE: begin
            if (grid_cfg.auto_mode) begin
               if (scan_state == STATUS_STOPPING) begin
                  scan_state = STATUS_FINISHED;
               end else if (scan_state == STATUS_SCANNING) begin
                  if (r.driver_fault) begin
                     scan_state = STATUS_ERROR;
                     o.reply = REPLY_DRIVER;
                  end else begin
                     record_point(r, o);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (scan_state == STATUS_FINISHED && prev != STATUS_FINISHED) scans_done++;
      o.status = scan_state;
      o.target_yaw_out = yaw_tgt;
      o.target_pitch_out = pitch_tgt;
      o.yaw_drive = yaw_on;
      o.pitch_drive = pitch_on;
      return o;
   endfunction

   function automatic req_type event_of(input logic [2:0] kind, input bit yat, input bit pat,
                                        input bit fault);
      req_type r;
      r.kind = kind;
      r.yaw_at_target = yat;
      r.pitch_at_target = pat;
      r.yaw_position = $urandom;
      r.pitch_position = $urandom;
      r.sample_value = $urandom;
      r.driver_fault = fault;
      return r;
   endfunction

   // Picks the event that moves the scan along from the predicted status, with a share of
   // random kinds mixed in.
   function automatic req_type next_event(input int fault_pct, input int noise_pct);
      logic [2:0] kind;
      int roll;
      roll = $urandom_range(0, 99);
      kind = KIND_CHECK;
      if (roll < noise_pct) begin
         kind = 3'($urandom_range(0, 6));
      end else begin
         case (scan_state)
            STATUS_UNINIT: kind = KIND_CONFIGURED;
            STATUS_READY: kind = (roll < 95) ? KIND_START : KIND_CONFIGURED;
            STATUS_SCANNING: begin
               if (noise_pct > 0 && roll >= 97) kind = KIND_STOP;
               else if (grid_cfg.auto_mode && dwell_asked) kind = KIND_DWELL_DONE;
               else kind = KIND_CHECK;
            end
            STATUS_STOPPING: kind = (grid_cfg.auto_mode && roll[0]) ? KIND_DWELL_DONE : KIND_CHECK;
            STATUS_WAITING: kind = (roll < 92) ? KIND_CONTINUE : KIND_STOP;
            default: kind = KIND_RESET;
         endcase
      end
      return event_of(kind, $urandom_range(0, 99) < 70, $urandom_range(0, 99) < 70,
                      $urandom_range(0, 99) < fault_pct);
   endfunction

   task automatic send_request(input req_type r);
      rsp_type want;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= r.kind;
      req_tdata <= {5'b0, r.driver_fault, r.sample_value, r.pitch_position, r.yaw_position,
                    r.pitch_at_target, r.yaw_at_target};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = scan_step(r);
      dwell_asked = want.start_dwell;
      expected_rsp.push_back(want);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_grid(input cfg_type c);
      logic [31:0] value;
      logic [2:0] idx;
      drain();
      for (int i = 0; i < 7; i++) begin
         idx = i[2:0];
         case (idx)
            REG_YAW_START: value = c.yaw_start;
            REG_YAW_END: value = c.yaw_end;
            REG_YAW_STEP: value = {1'($urandom_range(0, 1)), c.yaw_step};
            REG_PITCH_START: value = c.pitch_start;
            REG_PITCH_END: value = c.pitch_end;
            REG_PITCH_STEP: value = {1'($urandom_range(0, 1)), c.pitch_step};
            default: value = {31'($urandom), c.auto_mode};
         endcase
         csr_we <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      grid_cfg = c;
      settings_used++;
   endtask

   // Runs well-formed events until the scan finishes or max_items are sent; the first six check or
   // dwell-done events of the bench carry extreme position and measurement values.
   task automatic walk_grid(input int max_items);
      req_type r;
      int n;
      n = 0;
      while (n < max_items && !(n > 0 && scan_state == STATUS_FINISHED)) begin
         r = next_event(0, 0);
         if ((r.kind == KIND_CHECK || r.kind == KIND_DWELL_DONE) && extremes_used < 6) begin
            r.yaw_position = {32{extremes_used[0]}};
            r.pitch_position = {32{!extremes_used[0]}};
            r.sample_value = extremes_used[0] ? 32'h8000_0000 : 32'h7fff_ffff;
            extremes_used++;
         end
         send_request(r);
         n++;
      end
   endtask

   task automatic test_commands();
      send_request(event_of(KIND_START, 0, 0, 0));
      send_request(event_of(KIND_STOP, 0, 0, 0));
      send_request(event_of(KIND_RESET, 0, 0, 0));
      send_request(event_of(KIND_CONTINUE, 0, 0, 0));
      send_request(event_of(KIND_CHECK, 1, 1, 0));
      send_request(event_of(KIND_DWELL_DONE, 1, 1, 0));
      send_request(event_of(KIND_CONFIGURED, 0, 0, 1));
      send_request(event_of(KIND_CONFIGURED, 0, 0, 0));
      send_request(event_of(KIND_CONFIGURED, 0, 0, 0));
      send_request(event_of(KIND_START, 0, 0, 1));
      send_request(event_of(KIND_START, 0, 0, 0));
      send_request(event_of(KIND_CHECK, 0, 0, 1));
      send_request(event_of(KIND_RESET, 0, 0, 0));
      send_request(event_of(KIND_START, 0, 0, 0));
      send_request(event_of(KIND_CHECK, 0, 1, 0));
      send_request(event_of(KIND_CHECK, 0, 1, 1));
      send_request(event_of(KIND_CHECK, 1, 0, 0));
      send_request(event_of(KIND_CHECK, 1, 0, 0));
      send_request(event_of(KIND_CHECK, 1, 1, 0));
      send_request(event_of(KIND_CONTINUE, 0, 0, 0));
      send_request(event_of(KIND_STOP, 0, 0, 0));
      send_request(event_of(KIND_CHECK, 1, 1, 0));
      send_request(event_of(KIND_STOP, 0, 0, 0));
      send_request(event_of(KIND_RESET, 0, 0, 0));
      send_request(event_of(KIND_START, 0, 0, 0));
      send_request(event_of(KIND_CHECK, 1, 1, 0));
      send_request(event_of(KIND_CONTINUE, 0, 0, 1));
      send_request(event_of(KIND_RESET, 0, 0, 0));
   endtask

   task automatic test_manual_scan();
      cfg_type c;
      c.yaw_start = -32'sd10;
      c.yaw_end = 32'sd10;
      c.yaw_step = 31'd10;
      c.pitch_start = 32'sd100;
      c.pitch_end = 32'sd110;
      c.pitch_step = 31'd5;
      c.auto_mode = 1'b0;
      load_grid(c);
      walk_grid(200);
   endtask

   task automatic test_auto_scan();
      cfg_type c;
      c.yaw_start = 32'sd100;
      c.yaw_end = 32'sd130;
      c.yaw_step = 31'd15;
      c.pitch_start = -32'sd20;
      c.pitch_end = -32'sd10;
      c.pitch_step = 31'd10;
      c.auto_mode = 1'b1;
      load_grid(c);
      walk_grid(200);
   endtask

   task automatic test_extremes();
      cfg_type c;
      c.yaw_start = 32'h8000_0000;
      c.yaw_end = 32'h8000_0000;
      c.yaw_step = 31'h7fff_ffff;
      c.pitch_start = 32'h7fff_ffff;
      c.pitch_end = 32'h7fff_ffff;
      c.pitch_step = 31'h7fff_ffff;
      c.auto_mode = 1'b1;
      load_grid(c);
      repeat (40) send_request(next_event(2, 5));
      c.yaw_start = 32'h7fff_ffff;
      c.yaw_end = 32'h8000_0000;
      c.yaw_step = '0;
      c.pitch_start = 32'h8000_0000;
      c.pitch_end = 32'h8000_0000;
      c.pitch_step = '0;
      c.auto_mode = 1'b0;
      load_grid(c);
      repeat (40) send_request(next_event(2, 5));
   endtask

   task automatic test_random();
      cfg_type c;
      int phase_len;
      while (items_sent < 760) begin
         c.yaw_step = ($urandom_range(0, 9) == 0) ? 31'h7fff_ffff : 31'($urandom_range(1, 4096));
         c.yaw_start = $urandom;
         c.yaw_end = c.yaw_start + c.yaw_step * $urandom_range(0, 4)
                     + $urandom_range(0, c.yaw_step);
         c.pitch_step = ($urandom_range(0, 19) == 0) ? 31'd0 : 31'($urandom_range(1, 4096));
         c.pitch_start = $urandom;
         c.pitch_end = c.pitch_start + c.pitch_step * $urandom_range(0, 3);
         c.auto_mode = $urandom_range(0, 1);
         load_grid(c);
         phase_len = $urandom_range(40, 120);
         repeat (phase_len) send_request(next_event(3, 10));
      end
   endtask

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         default: rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_checked++;
         got.status = rsp_tdata[2:0];
         got.reply = rsp_tdata[4:3];
         got.target_yaw_out = rsp_tdata[36:5];
         got.target_pitch_out = rsp_tdata[68:37];
         got.load_target = rsp_tdata[69];
         got.yaw_drive = rsp_tdata[70];
         got.pitch_drive = rsp_tdata[71];
         got.point_valid = rsp_tdata[72];
         got.point_yaw = rsp_tdata[104:73];
         got.point_pitch = rsp_tdata[136:105];
         got.point_value = rsp_tdata[168:137];
         got.start_dwell = rsp_tdata[169];
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response", '0, '0);
         end else begin
            want = expected_rsp.pop_front();
            check_field("status", got.status, want.status);
            check_field("reply", got.reply, want.reply);
            check_field("target_yaw_out", got.target_yaw_out, want.target_yaw_out);
            check_field("target_pitch_out", got.target_pitch_out, want.target_pitch_out);
            check_field("load_target", got.load_target, want.load_target);
            check_field("yaw_drive", got.yaw_drive, want.yaw_drive);
            check_field("pitch_drive", got.pitch_drive, want.pitch_drive);
            check_field("point_valid", got.point_valid, want.point_valid);
            check_field("point_yaw", got.point_yaw, want.point_yaw);
            check_field("point_pitch", got.point_pitch, want.point_pitch);
            check_field("point_value", got.point_value, want.point_value);
            check_field("start_dwell", got.start_dwell, want.start_dwell);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", expected_rsp.size());
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_commands();
      test_manual_scan();
      test_auto_scan();
      test_extremes();
      test_random();
      drain();
      $display("Covered %0d requests over %0d register settings: %0d points recorded,",
               items_sent, settings_used, points_seen);
      $display("%0d scans ended, %0d responses checked, %0d mismatches.",
               scans_done, responses_checked, mismatches);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
